// File: hdl/trhn_pkg.sv
// Shared types, constants and helper functions for the torus nearest-rank picker.
`timescale 1ns / 1ps
package trhn_pkg;

  localparam int RANK_BITS = 20;
  localparam int LIST_MAX  = 4096;
  localparam int AXIS_BITS = 8;

  localparam int IDX_W   = $clog2(LIST_MAX);
  localparam int SIZE_W  = AXIS_BITS + 1;
  localparam int TOT_W   = 4 * SIZE_W;
  localparam int CMP_W   = (TOT_W > RANK_BITS) ? TOT_W : RANK_BITS;
  localparam int CNT_W   = $clog2(RANK_BITS);
  localparam int CFG_W   = 9;
  localparam int IDXR_W  = 3;
  localparam int HOP_W   = 10;
  localparam int BIDX_W  = 12;
  localparam int AXIS_CAP = 1 << AXIS_BITS;

  typedef enum logic [IDXR_W-1:0] {
    REG_SIZE_T = 3'd0,
    REG_SIZE_X = 3'd1,
    REG_SIZE_Y = 3'd2,
    REG_SIZE_Z = 3'd3,
    REG_WRAP   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_T, ST_DIV_X, ST_DIV_Y, ST_DIST, ST_UPD
  } back_state_e;

  typedef struct packed {
    logic [RANK_BITS-1:0] root;
    logic [RANK_BITS-1:0] cand;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic [SIZE_W-1:0] nt;
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [SIZE_W-1:0] nz;
    logic [2:0]        wrap;
    logic [TOT_W-1:0]  total;
  } cfg_t;

  // Zero reads as one, anything above the axis capacity saturates.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (int'(v) > AXIS_CAP) r = SIZE_W'(AXIS_CAP);
    else r = SIZE_W'(v);
    return r;
  endfunction

  function automatic logic [AXIS_BITS-1:0] axis_dist(input logic [AXIS_BITS-1:0] a,
                                                     input logic [AXIS_BITS-1:0] b,
                                                     input logic [SIZE_W-1:0]    size,
                                                     input logic                 wrap);
    logic [SIZE_W-1:0] d;
    logic [SIZE_W-1:0] alt;
    d   = (a > b) ? SIZE_W'(a - b) : SIZE_W'(b - a);
    alt = size - d;
    if (wrap && (d < size) && (alt < d)) d = alt;
    return AXIS_BITS'(d);
  endfunction

endpackage

// File: hdl/trhn_if.sv
// Valid/ready channel interfaces for the item and result streams.
`timescale 1ns / 1ps
interface trhn_in_if;
  logic                           valid;
  logic                           ready;
  logic [trhn_pkg::RANK_BITS-1:0] root_rank;
  logic [trhn_pkg::RANK_BITS-1:0] cand_rank;
  logic                           last;
  modport source (output valid, root_rank, cand_rank, last, input ready);
  modport sink   (input valid, root_rank, cand_rank, last, output ready);
endinterface

interface trhn_out_if;
  logic                        valid;
  logic                        ready;
  logic [trhn_pkg::HOP_W-1:0]  hop_count;
  logic [trhn_pkg::BIDX_W-1:0] best_index;
  logic [trhn_pkg::HOP_W-1:0]  best_hops;
  logic                        done_res;
  logic                        rank_error;
  modport source (output valid, hop_count, best_index, best_hops, done_res, rank_error,
                  input ready);
  modport sink   (input valid, hop_count, best_index, best_hops, done_res, rank_error,
                  output ready);
endinterface

// File: hdl/trhn_front.sv
// Front end: configuration registers, machine size product and the item queue.
`timescale 1ns / 1ps
module trhn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trhn_pkg::IDXR_W-1:0]   cfg_idx_i,
  input  logic [trhn_pkg::CFG_W-1:0]    cfg_data_i,
  trhn_in_if.sink                       in_i,
  input  logic                          pop_i,
  output trhn_pkg::queue_t              q_o,
  output trhn_pkg::cfg_t                cfg_o
);
  import trhn_pkg::*;

  logic [CFG_W-1:0] st_q, sx_q, sy_q, sz_q;
  logic [2:0]       wrap_q;
  logic [SIZE_W-1:0] nt, nx, ny, nz;
  logic [2*SIZE_W-1:0] p1_q;
  logic [3*SIZE_W-1:0] p2_q;
  logic [TOT_W-1:0]    tot_q;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= CFG_W'(1);
      sx_q   <= CFG_W'(1);
      sy_q   <= CFG_W'(1);
      sz_q   <= CFG_W'(1);
      wrap_q <= 3'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_T: st_q   <= cfg_data_i;
        REG_SIZE_X: sx_q   <= cfg_data_i;
        REG_SIZE_Y: sy_q   <= cfg_data_i;
        REG_SIZE_Z: sz_q   <= cfg_data_i;
        REG_WRAP:   wrap_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign nt = eff_size(st_q);
  assign nx = eff_size(sx_q);
  assign ny = eff_size(sy_q);
  assign nz = eff_size(sz_q);

  // Machine size settles through p1_q, p2_q and tot_q, long before any item needs it.
  always_ff @(posedge clk_i) begin
    p1_q  <= nt * nx;
    p2_q  <= p1_q * ny;
    tot_q <= p2_q * nz;
  end

  assign cfg_o = '{nt: nt, nx: nx, ny: ny, nz: nz, wrap: wrap_q, total: tot_q};

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign pop  = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= '{root: in_i.root_rank, cand: in_i.cand_rank,
                                   last: in_i.last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign q_o = '{valid: (cnt_q != 2'd0), item: mem_q[rd_ptr_q]};

endmodule

// File: hdl/trhn_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module trhn_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [trhn_pkg::RANK_BITS-1:0]  dividend_i,
  input  logic [trhn_pkg::SIZE_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [trhn_pkg::RANK_BITS-1:0]  quot_o,
  output logic [trhn_pkg::SIZE_W-1:0]     rem_o
);
  import trhn_pkg::*;

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RANK_BITS-1:0] q_q;
  logic [SIZE_W-1:0]    r_q, dv_q;
  logic [SIZE_W:0]      trial;
  logic                 fits;

  assign trial = {r_q, q_q[RANK_BITS-1]};
  assign fits  = (trial >= {1'b0, dv_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RANK_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[RANK_BITS-2:0], fits};
      r_q <= fits ? SIZE_W'(trial - {1'b0, dv_q}) : SIZE_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// File: hdl/trhn_back.sv
// Back end: rank decode sequencer, hop count, running minimum and result register.
`timescale 1ns / 1ps
module trhn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trhn_pkg::cfg_t     cfg_i,
  input  trhn_pkg::queue_t   q_i,
  output logic               pop_o,
  trhn_out_if.source         out_o
);
  import trhn_pkg::*;

  back_state_e state_q, state_d;
  item_t       item_q;

  logic                 start, done_r, done_c, div_done, load;
  logic [RANK_BITS-1:0] dvd_r, dvd_c, quot_r, quot_c;
  logic [SIZE_W-1:0]    divisor, rem_r, rem_c;

  logic [AXIS_BITS-1:0] xr_q, yr_q, zr_q, xc_q, yc_q, zc_q;
  logic [HOP_W-1:0]     hops_q;
  logic                 err_q;

  logic [IDX_W-1:0]  pos_q;
  logic              first_q;
  logic [HOP_W-1:0]  best_hops_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              upd;

  logic              out_valid_q;
  logic [HOP_W-1:0]  o_hops_q, o_best_hops_q;
  logic [BIDX_W-1:0] o_best_idx_q;
  logic              o_done_q, o_err_q;

  trhn_div u_div_root (
    .clk_i, .rst_ni, .start_i(start), .dividend_i(dvd_r), .divisor_i(divisor),
    .done_o(done_r), .quot_o(quot_r), .rem_o(rem_r)
  );

  trhn_div u_div_cand (
    .clk_i, .rst_ni, .start_i(start), .dividend_i(dvd_c), .divisor_i(divisor),
    .done_o(done_c), .quot_o(quot_c), .rem_o(rem_c)
  );

  assign div_done = done_r & done_c;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_i.valid) state_d = ST_DIV_T;
      ST_DIV_T: if (div_done) state_d = ST_DIV_X;
      ST_DIV_X: if (div_done) state_d = ST_DIV_Y;
      ST_DIV_Y: if (div_done) state_d = ST_DIST;
      ST_DIST:  state_d = ST_UPD;
      ST_UPD:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    start   = 1'b0;
    pop_o   = 1'b0;
    load    = 1'b0;
    dvd_r   = quot_r;
    dvd_c   = quot_c;
    divisor = cfg_i.nx;
    unique case (state_q)
      ST_IDLE: begin
        dvd_r   = q_i.item.root;
        dvd_c   = q_i.item.cand;
        divisor = cfg_i.nt;
        if (q_i.valid) begin
          pop_o = 1'b1;
          start = 1'b1;
        end
      end
      ST_DIV_T: start = div_done;
      ST_DIV_X: begin
        divisor = cfg_i.ny;
        start   = div_done;
      end
      ST_UPD:  load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= q_i.item;
    if (state_q == ST_DIV_X && div_done) begin
      xr_q <= AXIS_BITS'(rem_r);
      xc_q <= AXIS_BITS'(rem_c);
    end
    if (state_q == ST_DIV_Y && div_done) begin
      // A single plane along y leaves y and z at zero.
      if (cfg_i.ny == SIZE_W'(1)) begin
        yr_q <= '0; zr_q <= '0; yc_q <= '0; zc_q <= '0;
      end else begin
        yr_q <= AXIS_BITS'(rem_r);
        yc_q <= AXIS_BITS'(rem_c);
        zr_q <= AXIS_BITS'(quot_r);
        zc_q <= AXIS_BITS'(quot_c);
      end
    end
    if (state_q == ST_DIST) begin
      err_q  <= (CMP_W'(item_q.root) >= CMP_W'(cfg_i.total)) ||
                (CMP_W'(item_q.cand) >= CMP_W'(cfg_i.total));
      hops_q <= HOP_W'(axis_dist(xr_q, xc_q, cfg_i.nx, cfg_i.wrap[0])) +
                HOP_W'(axis_dist(yr_q, yc_q, cfg_i.ny, cfg_i.wrap[1])) +
                HOP_W'(axis_dist(zr_q, zc_q, cfg_i.nz, cfg_i.wrap[2]));
    end
  end

  assign upd = !err_q && (first_q || (hops_q < best_hops_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_q     <= 1'b1;
      best_hops_q <= '0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) out_valid_q <= 1'b0;
      if (load) begin
        out_valid_q <= 1'b1;
        if (item_q.last) begin
          pos_q       <= '0;
          first_q     <= 1'b1;
          best_hops_q <= '0;
          best_idx_q  <= '0;
        end else begin
          pos_q <= pos_q + IDX_W'(1);
          if (upd) begin
            first_q     <= 1'b0;
            best_hops_q <= hops_q;
            best_idx_q  <= pos_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_hops_q      <= err_q ? '0 : hops_q;
      o_best_hops_q <= upd ? hops_q : best_hops_q;
      o_best_idx_q  <= BIDX_W'(upd ? pos_q : best_idx_q);
      o_done_q      <= item_q.last;
      o_err_q       <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hop_count  = o_hops_q;
  assign out_o.best_index = o_best_idx_q;
  assign out_o.best_hops  = o_best_hops_q;
  assign out_o.done_res   = o_done_q;
  assign out_o.rank_error = o_err_q;

endmodule

// File: hdl/torus_rank_hop_nearest_core.sv
// Top level of the torus nearest-rank picker.
//
// Items arrive on in_i (root rank, candidate rank, last flag), one per list
// position; every item yields one result on out_o with its hop count, the
// running best index and best hop count, done_res and rank_error.
// The user sets machine sizes and the wrap mask via cfg_we_i / cfg_idx_i /
// cfg_data_i only while no item is in flight; the block does not enforce it.
// An item popped from the queue reaches the result register in steps: three
// sequential divisions (by t, x, y size) run on a pair of shared restoring
// dividers, one for each rank, each followed by a hand-over of the quotient,
// then the hop count is registered and the running minimum is updated.
// The back end pops the next item only after the previous one has reached the
// result register.
// A two-entry queue in front keeps taking transfers while the back end works.
// A result waits in its register while the receiver stalls; the back end then
// holds its finished item and the queue fills and drops ready.
// Reset returns sizes to one, the wrap mask to all axes, and starts a new list.
`timescale 1ns / 1ps
module torus_rank_hop_nearest_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trhn_pkg::IDXR_W-1:0]   cfg_idx_i,
  input  logic [trhn_pkg::CFG_W-1:0]    cfg_data_i,
  trhn_in_if.sink                       in_i,
  trhn_out_if.source                    out_o
);
  import trhn_pkg::*;

  queue_t q;
  cfg_t   cfg;
  logic   pop;

  trhn_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i, .pop_i(pop), .q_o(q), .cfg_o(cfg)
  );

  trhn_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_i(q), .pop_o(pop), .out_o
  );

endmodule

// File: hdl/trhn_checker.sv
// Port-level checks on the result stream, bound to the top level.
`timescale 1ns / 1ps
module trhn_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [trhn_pkg::HOP_W-1:0]   hop_count,
  input logic [trhn_pkg::HOP_W-1:0]   best_hops,
  input logic                         rank_error
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rank_error |-> hop_count == '0)
    else $error("hop count not zero on rank error");

  a_best_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !rank_error |-> best_hops <= hop_count)
    else $error("best hop count exceeds current hop count");

endmodule

bind torus_rank_hop_nearest_core trhn_checker u_trhn_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_o.valid), .out_ready(out_o.ready),
  .hop_count(out_o.hop_count), .best_hops(out_o.best_hops), .rank_error(out_o.rank_error)
);
